// ===== sv/subscript_markup_tokenizer_macros.svh =====
// Assertion macros used by the tokenizer checker.
`ifndef SUBSCRIPT_MARKUP_TOKENIZER_MACROS_SVH
`define SUBSCRIPT_MARKUP_TOKENIZER_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define SMT_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("subscript_markup_tokenizer check failed");

// Same, on the block's own clock and reset.
`define SMT_ASSERT(label, prop) \
   `SMT_ASSERT_CLK(label, clock, reset, prop)

`endif

// ===== sv/smt_pkg.sv =====
// Shared types and constants of the subscript markup tokenizer.
`default_nettype none
package smt_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int NEST_W  = 4;
   localparam int SKIP_W  = 8;
   localparam int MODE_W  = 2;
   localparam int DSEL_W  = 2;
   localparam int TDATA_W = 16;

   localparam int MAX_DEPTH_DEF = 10;

   // event kinds
   localparam logic [KIND_W-1:0] EV_CHAR    = 3'd0;
   localparam logic [KIND_W-1:0] EV_DRAW    = 3'd1;
   localparam logic [KIND_W-1:0] EV_SAVE    = 3'd2;
   localparam logic [KIND_W-1:0] EV_RESTORE = 3'd3;
   localparam logic [KIND_W-1:0] EV_SUB     = 3'd4;
   localparam logic [KIND_W-1:0] EV_SUP     = 3'd5;
   localparam logic [KIND_W-1:0] EV_NEWLINE = 3'd6;
   localparam logic [KIND_W-1:0] EV_END     = 3'd7;

   // scan modes
   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUP    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SKIP   = 2'd3;

   // event depth select
   localparam logic [DSEL_W-1:0] DSEL_NEST = 2'd0;
   localparam logic [DSEL_W-1:0] DSEL_UP   = 2'd1;
   localparam logic [DSEL_W-1:0] DSEL_DOWN = 2'd2;
   localparam logic [DSEL_W-1:0] DSEL_ZERO = 2'd3;

   // markup characters
   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;

   typedef struct packed {
      logic                load;
      logic                emit;
      logic [KIND_W-1:0]   kind;
      logic [DSEL_W-1:0]   dsel;
      logic                pass_byte;
      logic                last;
      logic                set_mode;
      logic [MODE_W-1:0]   mode;
      logic                set_pend;
      logic                clr_pend;
      logic                nest_inc;
      logic                nest_dec;
      logic                skip_inc;
      logic                skip_dec;
      logic                skip_clr;
   } smt_cmd_type;

   typedef struct packed {
      logic                is_zero;
      logic                is_under;
      logic                is_caret;
      logic                is_lbrace;
      logic                is_rbrace;
      logic                is_nl;
      logic [MODE_W-1:0]   mode;
      logic                pending;
      logic                nest_zero;
      logic                at_max;
      logic                skip_zero;
      logic                out_free;
   } smt_stat_type;

endpackage
`default_nettype wire

// ===== sv/smt_ctrl.sv =====
// Event sequencer: walks the events of one request, one per cycle unless the output register stalls.
`default_nettype none
module smt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire smt_pkg::smt_stat_type st,
   output smt_pkg::smt_cmd_type      cmd
);
   import smt_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_UNWIND  = 4'd2;
   localparam logic [3:0] S_CLOSE   = 4'd3;
   localparam logic [3:0] S_NL      = 4'd4;
   localparam logic [3:0] S_SAVE    = 4'd5;
   localparam logic [3:0] S_SCRIPT  = 4'd6;
   localparam logic [3:0] S_INNER   = 4'd7;
   localparam logic [3:0] S_IDRAW   = 4'd8;
   localparam logic [3:0] S_RESTORE = 4'd9;

   logic [3:0]   state_ff;
   logic [3:0]   state_in;
   logic [3:0]   next_st;
   smt_cmd_type  want;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      want    = '0;
      next_st = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            want.load = req_tvalid;
            if (req_tvalid) begin
               next_st = S_DECODE;
            end
         end
         S_DECODE: begin
            next_st = S_IDLE;
            if (st.is_zero) begin
               // end of text: flush, then unwind
               want.emit     = st.pending;
               want.kind     = EV_DRAW;
               want.dsel     = DSEL_NEST;
               want.clr_pend = 1'b1;
               next_st       = S_UNWIND;
            end else if (st.mode == MODE_SKIP) begin
               if (st.is_lbrace) begin
                  want.skip_inc = 1'b1;
               end else if (st.is_rbrace && st.skip_zero) begin
                  want.emit     = 1'b1;
                  want.kind     = EV_RESTORE;
                  want.dsel     = DSEL_DOWN;
                  want.last     = 1'b1;
                  want.nest_dec = 1'b1;
                  want.set_mode = 1'b1;
                  want.mode     = MODE_NORMAL;
                  want.skip_clr = 1'b1;
               end else if (st.is_rbrace) begin
                  want.skip_dec = 1'b1;
               end
            end else if (st.mode == MODE_NORMAL) begin
               if (st.is_under) begin
                  want.set_mode = 1'b1;
                  want.mode     = MODE_SUB;
               end else if (st.is_caret) begin
                  want.set_mode = 1'b1;
                  want.mode     = MODE_SUP;
               end else if (st.is_rbrace && !st.nest_zero) begin
                  want.emit     = 1'b1;
                  want.kind     = EV_DRAW;
                  want.dsel     = DSEL_NEST;
                  want.clr_pend = 1'b1;
                  next_st       = S_CLOSE;
               end else if (st.is_nl) begin
                  want.emit     = st.pending;
                  want.kind     = EV_DRAW;
                  want.dsel     = DSEL_NEST;
                  want.clr_pend = 1'b1;
                  next_st       = S_NL;
               end else begin
                  want.emit      = 1'b1;
                  want.kind      = EV_CHAR;
                  want.dsel      = DSEL_NEST;
                  want.pass_byte = 1'b1;
                  want.last      = 1'b1;
                  want.set_pend  = 1'b1;
               end
            end else begin
               if (st.is_under || st.is_caret) begin
                  // doubled markup: literal
                  want.emit      = 1'b1;
                  want.kind      = EV_CHAR;
                  want.dsel      = DSEL_NEST;
                  want.pass_byte = 1'b1;
                  want.last      = 1'b1;
                  want.set_pend  = 1'b1;
                  want.set_mode  = 1'b1;
                  want.mode      = MODE_NORMAL;
               end else begin
                  want.emit     = st.pending;
                  want.kind     = EV_DRAW;
                  want.dsel     = DSEL_NEST;
                  want.clr_pend = 1'b1;
                  next_st       = S_SAVE;
               end
            end
         end
         S_UNWIND: begin
            want.emit = 1'b1;
            if (!st.nest_zero) begin
               want.kind     = EV_RESTORE;
               want.dsel     = DSEL_DOWN;
               want.nest_dec = 1'b1;
            end else begin
               want.kind     = EV_END;
               want.dsel     = DSEL_ZERO;
               want.last     = 1'b1;
               want.set_mode = 1'b1;
               want.mode     = MODE_NORMAL;
               want.skip_clr = 1'b1;
               want.clr_pend = 1'b1;
               next_st       = S_IDLE;
            end
         end
         S_CLOSE: begin
            want.emit     = 1'b1;
            want.kind     = EV_RESTORE;
            want.dsel     = DSEL_DOWN;
            want.last     = 1'b1;
            want.nest_dec = 1'b1;
            want.set_mode = 1'b1;
            want.mode     = MODE_NORMAL;
            want.skip_clr = 1'b1;
            next_st       = S_IDLE;
         end
         S_NL: begin
            want.emit = 1'b1;
            want.kind = EV_NEWLINE;
            want.dsel = DSEL_NEST;
            want.last = 1'b1;
            next_st   = S_IDLE;
         end
         S_SAVE: begin
            want.emit = 1'b1;
            want.kind = EV_SAVE;
            want.dsel = DSEL_NEST;
            next_st   = S_SCRIPT;
         end
         S_SCRIPT: begin
            want.emit = 1'b1;
            want.kind = (st.mode == MODE_SUB) ? EV_SUB : EV_SUP;
            want.dsel = DSEL_UP;
            if (st.is_lbrace) begin
               want.last     = 1'b1;
               want.nest_inc = 1'b1;
               want.skip_clr = 1'b1;
               want.set_mode = 1'b1;
               want.mode     = st.at_max ? MODE_SKIP : MODE_NORMAL;
               next_st       = S_IDLE;
            end else if (st.at_max) begin
               next_st = S_RESTORE;
            end else begin
               next_st = S_INNER;
            end
         end
         S_INNER: begin
            want.emit = 1'b1;
            want.dsel = DSEL_UP;
            if (st.is_rbrace) begin
               want.kind     = EV_DRAW;
               want.clr_pend = 1'b1;
               next_st       = S_RESTORE;
            end else if (st.is_nl) begin
               want.kind = EV_NEWLINE;
               next_st   = S_IDRAW;
            end else begin
               want.kind      = EV_CHAR;
               want.pass_byte = 1'b1;
               next_st        = S_IDRAW;
            end
         end
         S_IDRAW: begin
            want.emit     = 1'b1;
            want.kind     = EV_DRAW;
            want.dsel     = DSEL_UP;
            want.clr_pend = 1'b1;
            next_st       = S_RESTORE;
         end
         S_RESTORE: begin
            want.emit     = 1'b1;
            want.kind     = EV_RESTORE;
            want.dsel     = DSEL_NEST;
            want.last     = 1'b1;
            want.set_mode = 1'b1;
            want.mode     = MODE_NORMAL;
            next_st       = S_IDLE;
         end
         default: begin
            next_st = S_IDLE;
         end
      endcase

      // hold everything while an event waits on a full, stalled output register
      if (want.emit && !st.out_free) begin
         cmd      = '0;
         state_in = state_ff;
      end else begin
         cmd      = want;
         state_in = next_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/smt_dp.sv =====
// Datapath: scan state registers and the result output register.
`default_nettype none
module smt_dp #(
   parameter int MAX_DEPTH = smt_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [smt_pkg::BYTE_W-1:0]  req_tdata,
   input  wire smt_pkg::smt_cmd_type        cmd,
   output smt_pkg::smt_stat_type            st,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [smt_pkg::TDATA_W-1:0]      rsp_tdata,
   output logic [smt_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);
   import smt_pkg::*;

   logic [BYTE_W-1:0]  byte_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [NEST_W-1:0]  nest_ff;
   logic [SKIP_W-1:0]  skip_ff;
   logic               pend_ff;
   logic               ovalid_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [BYTE_W-1:0]  obyte_ff;
   logic [NEST_W-1:0]  depth_ff;
   logic               last_ff;

   logic [NEST_W:0]    nest_p1;
   logic [NEST_W-1:0]  depth_in;

   assign nest_p1 = {1'b0, nest_ff} + {{NEST_W{1'b0}}, 1'b1};

   always_comb begin
      st.is_zero   = (byte_ff == CH_NUL);
      st.is_under  = (byte_ff == CH_UNDER);
      st.is_caret  = (byte_ff == CH_CARET);
      st.is_lbrace = (byte_ff == CH_LBRACE);
      st.is_rbrace = (byte_ff == CH_RBRACE);
      st.is_nl     = (byte_ff == CH_NL);
      st.mode      = mode_ff;
      st.pending   = pend_ff;
      st.nest_zero = (nest_ff == '0);
      st.at_max    = (nest_p1 >= (NEST_W+1)'(MAX_DEPTH));
      st.skip_zero = (skip_ff == '0);
      st.out_free  = !ovalid_ff || rsp_tready;
   end

   always_comb begin
      unique case (cmd.dsel)
         DSEL_NEST: depth_in = nest_ff;
         DSEL_UP:   depth_in = nest_p1[NEST_W-1:0];
         DSEL_DOWN: depth_in = nest_ff - {{(NEST_W-1){1'b0}}, 1'b1};
         DSEL_ZERO: depth_in = '0;
         default:   depth_in = '0;
      endcase
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         nest_ff <= '0;
         skip_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.set_mode) begin
            mode_ff <= cmd.mode;
         end
         if (cmd.nest_inc) begin
            nest_ff <= nest_p1[NEST_W-1:0];
         end else if (cmd.nest_dec && (nest_ff != '0)) begin
            nest_ff <= nest_ff - {{(NEST_W-1){1'b0}}, 1'b1};
         end
         if (cmd.skip_clr) begin
            skip_ff <= '0;
         end else if (cmd.skip_inc && (skip_ff != {SKIP_W{1'b1}})) begin
            skip_ff <= skip_ff + {{(SKIP_W-1){1'b0}}, 1'b1};
         end else if (cmd.skip_dec) begin
            skip_ff <= skip_ff - {{(SKIP_W-1){1'b0}}, 1'b1};
         end
         if (cmd.set_pend) begin
            pend_ff <= 1'b1;
         end else if (cmd.clr_pend) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // request byte and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_tdata;
      end
      if (cmd.emit) begin
         kind_ff  <= cmd.kind;
         obyte_ff <= cmd.pass_byte ? byte_ff : '0;
         depth_ff <= depth_in;
         last_ff  <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(TDATA_W-BYTE_W-NEST_W){1'b0}}, depth_ff, obyte_ff};

endmodule
`default_nettype wire

// ===== sv/subscript_markup_tokenizer.sv =====
// Top level of the subscript markup tokenizer.
`default_nettype none
// Turns a stream of text bytes into layout events for sub/superscript
// markup. Each request carries one byte on req_tdata; a zero byte ends the
// text, unwinds every open level, sends an end event and returns the block
// to its reset state. Each byte yields zero or more events on the rsp side,
// the final one of the byte flagged by rsp_tlast; a byte that yields nothing
// produces no response at all. The sequencer takes a byte, decodes it in
// the next cycle and then, unless rsp stalls, sends one event per cycle
// into the single output register. The output register lets a new byte be
// taken while the last event of the previous one still waits;
// back-pressure on rsp stalls the sequencer. Bytes that would sit at
// nest level MAX_DEPTH are dropped while braces are counted.
module subscript_markup_tokenizer #(
   parameter int MAX_DEPTH = smt_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // tdata: [7:0] text_byte
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [smt_pkg::BYTE_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // tdata: [7:0] out_byte, [11:8] nest_depth, [15:12] zero
   output logic [smt_pkg::TDATA_W-1:0]      rsp_tdata,
   // tuser: [2:0] event_kind
   output logic [smt_pkg::KIND_W-1:0]       rsp_tuser,
   // tlast: last_of_run
   output logic                             rsp_tlast
);
   import smt_pkg::*;

   smt_cmd_type  cmd;
   smt_stat_type st;

   smt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   smt_dp #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== sv/smt_chk.sv =====
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none
`include "subscript_markup_tokenizer_macros.svh"
module smt_chk #(
   parameter int MAX_DEPTH = smt_pkg::MAX_DEPTH_DEF
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [smt_pkg::TDATA_W-1:0] rsp_tdata,
   input wire logic [smt_pkg::KIND_W-1:0]  rsp_tuser,
   input wire logic                        rsp_tlast
);
   import smt_pkg::*;

   // stalled response holds
   `SMT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // one request in flight: busy right after a take
   `SMT_ASSERT(a_busy_after_take, req_tvalid && req_tready |=> !req_tready)

   // end of text closes the run at level zero
   `SMT_ASSERT(a_end_last, rsp_tvalid && (rsp_tuser == EV_END) |-> rsp_tlast && (rsp_tdata[11:8] == 4'd0))

   // only char events carry a byte; pad bits stay clear
   `SMT_ASSERT(a_byte_char_only, rsp_tvalid && (rsp_tuser != EV_CHAR) |-> (rsp_tdata[7:0] == 8'd0) && (rsp_tdata[15:12] == 4'd0))

   // no event sits deeper than the depth limit
   `SMT_ASSERT(a_depth_max, rsp_tvalid |-> (rsp_tdata[11:8] <= NEST_W'(MAX_DEPTH)))

endmodule

bind subscript_markup_tokenizer smt_chk #(.MAX_DEPTH(MAX_DEPTH)) u_smt_chk (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for subscript_markup_tokenizer: text bytes in, layout events checked.
import smt_pkg::*;

typedef struct {
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] ch;
   logic [NEST_W-1:0] depth;
   logic              last;
} layout_event_t;

// Tracks the tokenizer state and keeps the layout events each request should produce.
class tokenizer_scoreboard;
   layout_event_t     expected_events[$];
   logic [NEST_W-1:0] level;
   logic [SKIP_W-1:0] skip;
   logic [MODE_W-1:0] mode;
   logic              pending;
   int                mismatches;
   int                events_checked;
   int                texts_ended;
   int                deepest;
   int                ceiling_hits;

   function new();
      clear_state();
   endfunction

   function void clear_state();
      level   = '0;
      skip    = '0;
      mode    = MODE_NORMAL;
      pending = 1'b0;
   endfunction

   function int outstanding();
      return expected_events.size();
   endfunction

   function void push(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] ch,
                      input int depth);
      layout_event_t ev;
      ev.kind  = kind;
      ev.ch    = ch;
      ev.depth = depth[NEST_W-1:0];
      ev.last  = 1'b0;
      expected_events.push_back(ev);
   endfunction

   function void draw_now(input int depth);
      push(EV_DRAW, '0, depth);
      pending = 1'b0;
   endfunction

   function void draw_if_pending(input int depth);
      if (pending) draw_now(depth);
   endfunction

   function void give_char(input logic [BYTE_W-1:0] c, input int depth);
      push(EV_CHAR, c, depth);
      pending = 1'b1;
   endfunction

   function void close_level();
      if (level > 0) level = level - 1'b1;
      push(EV_RESTORE, '0, level);
      mode = MODE_NORMAL;
      skip = '0;
   endfunction

   // Work out the events caused by one accepted text byte.
   function void note_request(input logic [BYTE_W-1:0] c);
      int                lv;
      int                first;
      logic [KIND_W-1:0] script;
      lv    = level;
      first = expected_events.size();
      if (c == CH_NUL) begin
         // end of text: dangling prefix dropped, every level unwound
         draw_if_pending(lv);
         while (lv > 0) begin
            lv--;
            push(EV_RESTORE, '0, lv);
         end
         push(EV_END, '0, 0);
         texts_ended++;
         clear_state();
      end else if (mode == MODE_SKIP) begin
         if (c == CH_LBRACE) begin
            if (skip != '1) skip = skip + 1'b1;
            else ceiling_hits++;
         end else if (c == CH_RBRACE) begin
            if (skip == 0) close_level();
            else skip = skip - 1'b1;
         end
      end else if (mode == MODE_NORMAL) begin
         if (c == CH_UNDER) mode = MODE_SUB;
         else if (c == CH_CARET) mode = MODE_SUP;
         else if (c == CH_RBRACE && lv > 0) begin
            draw_now(lv);
            close_level();
         end else if (c == CH_NL) begin
            draw_if_pending(lv);
            push(EV_NEWLINE, '0, lv);
         end else begin
            give_char(c, lv);
         end
      end else begin
         script = (mode == MODE_SUB) ? EV_SUB : EV_SUP;
         mode   = MODE_NORMAL;
         if (c == CH_UNDER || c == CH_CARET) begin
            give_char(c, lv);    // doubled prefix is a literal
         end else begin
            draw_if_pending(lv);
            push(EV_SAVE, '0, lv);
            push(script, '0, lv + 1);
            if (c == CH_LBRACE) begin
               level = lv + 1;
               skip  = '0;
               if (level >= MAX_DEPTH_DEF) mode = MODE_SKIP;
            end else begin
               // one-character script; dropped when it would sit at the depth limit
               if (lv + 1 < MAX_DEPTH_DEF) begin
                  if (c == CH_RBRACE) begin
                     draw_now(lv + 1);
                  end else if (c == CH_NL) begin
                     draw_if_pending(lv + 1);
                     push(EV_NEWLINE, '0, lv + 1);
                     draw_now(lv + 1);
                  end else begin
                     give_char(c, lv + 1);
                     draw_now(lv + 1);
                  end
               end
               push(EV_RESTORE, '0, lv);
            end
         end
      end
      if (level > deepest) deepest = level;
      if (expected_events.size() > first)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endfunction

   // Compare one accepted event with the oldest expectation.
   function void check_event(input logic [KIND_W-1:0] kind, input logic [TDATA_W-1:0] data,
                             input logic last);
      layout_event_t ev;
      if (expected_events.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected event: kind %0d byte %02h depth %0d last %0b",
                     kind, data[7:0], data[11:8], last);
         mismatches++;
         return;
      end
      ev = expected_events.pop_front();
      events_checked++;
      if (kind !== ev.kind || data[7:0] !== ev.ch || data[11:8] !== ev.depth
          || data[15:12] !== 4'h0 || last !== ev.last) begin
         if (mismatches < 10)
            $display("event %0d mismatch: expected kind %0d byte %02h depth %0d last %0b pad 0, got kind %0d byte %02h depth %0d last %0b pad %0h",
                     events_checked, ev.kind, ev.ch, ev.depth, ev.last,
                     kind, data[7:0], data[11:8], last, data[15:12]);
         mismatches++;
      end
   endfunction
endclass

module tb_top;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [BYTE_W-1:0]   req_tdata;    // [7:0] text_byte
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [TDATA_W-1:0]  rsp_tdata;    // [7:0] out_byte, [11:8] nest_depth, [15:12] zero
   logic [KIND_W-1:0]   rsp_tuser;    // [2:0] event_kind
   logic                rsp_tlast;    // last_of_run

   tokenizer_scoreboard sb = new();

   int send_idle_pct;     // chance per cycle that the sender holds off
   int stall_pct;         // chance per cycle that the receiver stalls
   int requests_sent;
   int requests_skipped;  // bytes sent while inside a skipped region

   subscript_markup_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver: ready is redrawn every falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Event monitor: an event on rsp is taken at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_event(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Present one byte from a falling edge and hold it until accepted.
   // Valid is left high; the next call or a drain decides what follows.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sb.mode == MODE_SKIP) requests_skipped++;
      sb.note_request(b);
      requests_sent++;
   endtask

   // Stop sending and hold off until every expected event has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Random text: mostly well-formed markup steered toward a per-text
   // nesting target, plus some noise bytes and early ends of text.
   task automatic send_tokens(input int count);
      int                done;
      int                target;
      int                pick;
      int                w_open;
      int                w_close;
      logic [BYTE_W-1:0] b;
      done   = 0;
      target = $urandom_range(0, 11);
      while (done < count) begin
         if (sb.mode == MODE_SKIP) begin
            // skipped region: lean toward closing braces so it ends soon
            pick = $urandom_range(99);
            if (pick < 2) send_byte(CH_NUL);
            else if (pick < 47) send_byte(CH_RBRACE);
            else if (pick < 67) send_byte(CH_LBRACE);
            else send_byte($urandom_range(1, 255));
            done++;
            continue;
         end
         if (sb.level == target && $urandom_range(9) == 0) target = $urandom_range(0, 11);
         w_open  = (sb.level < target) ? 30 : 6;
         w_close = (sb.level > target) ? 30 : 8;
         pick    = $urandom_range(99);
         if (pick < 3) begin
            send_byte(CH_NUL);
            target = $urandom_range(0, 11);
            done++;
         end else if (pick < 12) begin
            send_byte($urandom_range(0, 255));
            done++;
         end else if (pick < 20) begin
            send_byte(CH_NL);
            done++;
         end else if (pick < 32) begin
            // one-character script with a random, sometimes special, body
            send_byte($urandom_range(1) ? CH_UNDER : CH_CARET);
            case ($urandom_range(4))
               0: b = CH_NL;
               1: b = CH_RBRACE;
               default: b = $urandom_range(1, 255);
            endcase
            send_byte(b);
            done += 2;
         end else if (pick < 40) begin
            send_byte($urandom_range(1) ? CH_UNDER : CH_CARET);
            send_byte($urandom_range(1) ? CH_UNDER : CH_CARET);
            done += 2;
         end else if (pick < 40 + w_open) begin
            send_byte($urandom_range(1) ? CH_UNDER : CH_CARET);
            send_byte(CH_LBRACE);
            done += 2;
         end else if (pick < 40 + w_open + w_close) begin
            send_byte(CH_RBRACE);
            done++;
         end else begin
            send_byte($urandom_range(1, 255));
            done++;
         end
      end
   endtask

   initial begin
      // plain bytes, stray close, scripts, literals, a nested level, end cases
      logic [BYTE_W-1:0] opening_text [24] = '{
         8'h61, 8'hFF, 8'h01, CH_NL, CH_RBRACE,
         CH_UNDER, 8'h78, CH_CARET, CH_NL, CH_UNDER, CH_RBRACE,
         CH_CARET, CH_CARET, CH_UNDER, CH_UNDER, CH_UNDER, CH_CARET,
         CH_UNDER, CH_LBRACE, 8'h71, CH_CARET, CH_NUL,
         CH_NL, CH_NUL
      };
      int send_plan  [4] = '{0, 77, 0, 14};
      int stall_plan [4] = '{0, 0, 77, 14};

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      requests_sent    = 0;
      requests_skipped = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_text[i]) send_byte(opening_text[i]);
      drain();

      // Walk to the depth limit: a dropped one-character script at the last
      // level, then a skipped region with nested braces that counts back
      // down and finally closes the level.
      repeat (MAX_DEPTH_DEF - 1) begin
         send_byte(CH_CARET);
         send_byte(CH_LBRACE);
      end
      send_byte(CH_CARET);
      send_byte(8'h77);
      send_byte(CH_UNDER);
      send_byte(CH_LBRACE);
      repeat (4) send_byte(CH_LBRACE);
      repeat (4) send_byte(CH_RBRACE);
      send_byte(8'h7A);
      send_byte(CH_RBRACE);
      send_byte(8'h63);
      send_byte(CH_NUL);
      drain();

      // Random part, cycling through the idle/stall mixes twice; each
      // segment ends by waiting for every outstanding event.
      for (int round = 0; round < 2; round++) begin
         for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_plan[ph];
            stall_pct     = stall_plan[ph];
            send_tokens(49);
            drain();
         end
      end
      send_byte(CH_NUL);
      drain();
      repeat (20) @(posedge clock);

      $display("Run covered %0d text bytes (%0d inside skipped regions) and %0d texts.",
               requests_sent, requests_skipped, sb.texts_ended);
      $display("%0d events checked, deepest level %0d, brace ceiling reached %0d times.",
               sb.events_checked, sb.deepest, sb.ceiling_hits);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d events never seen", sb.mismatches, sb.outstanding());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
